### src/psm_pkg.sv
`default_nettype none

package psm_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned MAX_QUBITS = 32;
    localparam int unsigned PAULI_W    = 2;
    localparam int unsigned PHASE_W    = 2;
    localparam int unsigned TREE_LVLS  = 5;
    localparam int unsigned S_DATA_W   = 128;
    localparam int unsigned M_DATA_W   = 72;

    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [PAULI_W-1:0] pauli_t;

    // per-qubit outcome: product operator and scalar factor code (0=1, 1=i, 2=-1, 3=-i)
    typedef struct packed {
        pauli_t pauli;
        phase_t code;
    } lane_res_t;

endpackage

`default_nettype wire

### src/psm_lane.sv
`default_nettype none

module psm_lane (
    input  wire psm_pkg::pauli_t    left_q,
    input  wire psm_pkg::pauli_t    right_q,
    output psm_pkg::lane_res_t      res
);

    logic a0, a1, b0, b1;
    logic lo, hi;

    always_comb begin
        a0 = left_q[0];
        a1 = left_q[1];
        b0 = right_q[0];
        b1 = right_q[1];
        lo = (~a1 & a0 & b1) | (a0 & b1 & ~b0) | (a1 & ~a0 & b0) | (a1 & ~b1 & b0);
        hi = (~a1 & a0 & b1 & b0) | (a1 & ~a0 & ~b1 & b0) | (a1 & a0 & b1 & ~b0);
        res.pauli = left_q ^ right_q;
        res.code  = {hi, lo};
    end

endmodule

`default_nettype wire

### src/psm_merge.sv
`default_nettype none

module psm_merge (
    input  wire psm_pkg::phase_t [psm_pkg::MAX_QUBITS-1:0] codes,
    output psm_pkg::phase_t                                 word_phase
);

    // balanced mod-4 adder tree, one level per pairing
    psm_pkg::phase_t lvl [0:psm_pkg::TREE_LVLS][0:psm_pkg::MAX_QUBITS-1];

    always_comb begin
        for (int l = 0; l <= psm_pkg::TREE_LVLS; l++) begin
            for (int k = 0; k < psm_pkg::MAX_QUBITS; k++) begin
                lvl[l][k] = '0;
            end
        end
        for (int k = 0; k < psm_pkg::MAX_QUBITS; k++) begin
            lvl[0][k] = codes[k];
        end
        for (int l = 1; l <= psm_pkg::TREE_LVLS; l++) begin
            for (int k = 0; k < (psm_pkg::MAX_QUBITS >> l); k++) begin
                lvl[l][k] = lvl[l-1][2*k] + lvl[l-1][2*k+1];
            end
        end
        word_phase = lvl[psm_pkg::TREE_LVLS][0];
    end

endmodule

`default_nettype wire

### src/pauli_string_multiply_core.sv
`default_nettype none

// channel | ports        | payload
// --------+--------------+-----------------------------------------------------
// s_      | tvalid/tready| tdata: left_word[63:0], right_word[127:64]; tlast: last_word
// m_      | tvalid/tready| tdata: product_word[63:0], phase[65:64], pad; tlast: phase_final
//
// One word pair per cycle unless m_ stalls; result valid the cycle after accept.
// Throughput is set by the single output register: a new request is taken whenever
// the register is empty or its result is being taken in the same cycle.
// Lanes and the mod-4 phase tree are evaluated in the accept cycle.
// aresetn (synchronous, active low) clears the output valid and the phase accumulator.
// A stalled m_ side holds the result and backpressures s_tready.

module pauli_string_multiply_core #(
    parameter int unsigned QUBITS_PER_WORD = 32
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [psm_pkg::S_DATA_W-1:0]     s_tdata,   // left_word, right_word
    input  wire                              s_tlast,   // last_word
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [psm_pkg::M_DATA_W-1:0]     m_tdata,   // product_word, phase, zero pad
    output logic                             m_tlast    // phase_final
);

    localparam int unsigned LANES = (QUBITS_PER_WORD < 1) ? 1 :
                                    (QUBITS_PER_WORD > psm_pkg::MAX_QUBITS) ?
                                    psm_pkg::MAX_QUBITS : QUBITS_PER_WORD;

    logic [psm_pkg::WORD_W-1:0] left_word, right_word, product_word;
    psm_pkg::phase_t [psm_pkg::MAX_QUBITS-1:0] codes;
    psm_pkg::phase_t word_phase;
    psm_pkg::phase_t phase_sum;
    logic accept;

    logic                       valid_reg, valid_next;
    logic [psm_pkg::WORD_W-1:0] prod_reg, prod_next;
    psm_pkg::phase_t            phase_reg, phase_next;
    logic                       last_reg, last_next;
    psm_pkg::phase_t            acc_reg, acc_next;

    assign left_word  = s_tdata[psm_pkg::WORD_W-1:0];
    assign right_word = s_tdata[2*psm_pkg::WORD_W-1:psm_pkg::WORD_W];

    genvar q;
    generate
        for (q = 0; q < psm_pkg::MAX_QUBITS; q++) begin : g_lane
            if (q < LANES) begin : g_used
                psm_pkg::lane_res_t res;
                psm_lane u_lane (
                    .left_q  (left_word[2*q +: psm_pkg::PAULI_W]),
                    .right_q (right_word[2*q +: psm_pkg::PAULI_W]),
                    .res     (res)
                );
                assign product_word[2*q +: psm_pkg::PAULI_W] = res.pauli;
                assign codes[q] = res.code;
            end else begin : g_idle
                assign product_word[2*q +: psm_pkg::PAULI_W] = '0;
                assign codes[q] = '0;
            end
        end
    endgenerate

    psm_merge u_merge (
        .codes      (codes),
        .word_phase (word_phase)
    );

    assign s_tready  = !valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign phase_sum = acc_reg + word_phase;

    always_comb begin
        valid_next = valid_reg;
        prod_next  = prod_reg;
        phase_next = phase_reg;
        last_next  = last_reg;
        acc_next   = acc_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            valid_next = 1'b1;
            prod_next  = product_word;
            phase_next = phase_sum;
            last_next  = s_tlast;
            acc_next   = s_tlast ? '0 : phase_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            acc_reg   <= acc_next;
        end
        prod_reg  <= prod_next;
        phase_reg <= phase_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(psm_pkg::M_DATA_W - psm_pkg::WORD_W - psm_pkg::PHASE_W){1'b0}},
                       phase_reg, prod_reg};
    assign m_tlast  = last_reg;

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> acc_reg == '0)
        else $error("phase accumulator not cleared after last request");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid && m_tlast == $past(s_tlast))
        else $error("accepted request did not produce a result");

    a_phase_carried: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_tlast |=> m_tdata[psm_pkg::WORD_W +: psm_pkg::PHASE_W] == acc_reg)
        else $error("reported phase differs from running phase");

    a_product_xor: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tdata[psm_pkg::WORD_W-1:0] == $past(product_word))
        else $error("product word mismatch");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[psm_pkg::M_DATA_W-1:psm_pkg::WORD_W+psm_pkg::PHASE_W] == '0)
        else $error("pad bits of result not zero");

endmodule

`default_nettype wire
